FILE: src/ctc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants of the cascading timer channels: beat layouts,
// item kinds, control word fields, prescaler codes and catch-up handshake.
// ----------------------------------------------------------------------------
package ctc_pkg;

	// field widths
	localparam int CNT_W  = 16;
	localparam int ACC_W  = 11;
	localparam int CU_W   = 10;
	localparam int IRQ_W  = 4;
	localparam int FIFO_W = 2;

	// item kinds
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_RELOAD = 2'd1;
	localparam logic [1:0] KIND_CTRL   = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	// control word bit positions
	localparam int CTRL_CAS_BIT = 2;
	localparam int CTRL_IRQ_BIT = 6;
	localparam int CTRL_EN_BIT  = 7;

	// prescaler select codes
	localparam logic [1:0] PSC_DIV1    = 2'd0;
	localparam logic [1:0] PSC_DIV64   = 2'd1;
	localparam logic [1:0] PSC_DIV256  = 2'd2;
	localparam logic [1:0] PSC_DIV1024 = 2'd3;

	typedef logic [CNT_W-1:0]        count_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [ACC_W:0]   accx_t;
	typedef logic [CU_W-1:0]         steps_t;

	// prescale accumulator start value on enable: first increment two ticks late
	localparam acc_t ACC_START = -11'sd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  channel;
		logic [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic [15:0]       read_data;
		logic [IRQ_W-1:0]  irq_flags;
		logic [FIFO_W-1:0] fifo_notify;
	} out_item_t;

	// bank to catch-up sequencer
	typedef struct packed {
		logic   load;
		steps_t steps;
	} cu_ctl_t;

	// catch-up sequencer to bank
	typedef struct packed {
		logic   busy;
		logic   ovf;
		count_t count;
	} cu_stat_t;

	// divisor as a left shift amount
	function automatic logic [3:0] div_shift(input logic [1:0] sel);
		logic [3:0] s;
		case (sel)
			PSC_DIV1:    s = 4'd0;
			PSC_DIV64:   s = 4'd6;
			PSC_DIV256:  s = 4'd8;
			PSC_DIV1024: s = 4'd10;
			default:     s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

FILE: src/ctc_catchup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_catchup
// Catch-up sequencer. After a divisor drop on a running channel it works off
// the owed counter increments, jumping straight to the next overflow, so one
// overflow of the target channel is handled per cycle.
// ----------------------------------------------------------------------------
module ctc_catchup (
	input  logic              clk,
	input  logic              arst_n,
	input  ctc_pkg::cu_ctl_t  ctl,
	input  ctc_pkg::count_t   count,
	input  ctc_pkg::count_t   reload,
	output ctc_pkg::cu_stat_t stat
);

	ctc_pkg::steps_t          steps_q, steps_d;
	logic [ctc_pkg::CNT_W:0]  wrap_gap, steps_ext;
	logic                     busy, ovf;

	// distance to the next wrap of the target counter
	assign busy      = (steps_q != '0);
	assign wrap_gap  = {1'b1, {ctc_pkg::CNT_W{1'b0}}} - {1'b0, count};
	assign steps_ext = {{(ctc_pkg::CNT_W + 1 - ctc_pkg::CU_W){1'b0}}, steps_q};
	assign ovf       = busy && (steps_ext >= wrap_gap);

	// remaining increments
	always_comb begin
		if (ctl.load) begin
			steps_d = ctl.steps;
		end else if (ovf) begin
			steps_d = steps_q - wrap_gap[ctc_pkg::CU_W-1:0];
		end else begin
			steps_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else begin
			steps_q <= steps_d;
		end
	end

	// new counter value for the target channel this cycle
	always_comb begin
		stat.busy  = busy;
		stat.ovf   = ovf;
		stat.count = ovf ? reload
			: count + {{(ctc_pkg::CNT_W - ctc_pkg::CU_W){1'b0}}, steps_q};
	end

endmodule

FILE: src/ctc_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_bank
// Channel state and the single-pass update for one item: prescale step,
// overflow ripple through cascade channels, staged reloads, control and
// read handling. Hosts the catch-up sequencer and its pending flags.
// ----------------------------------------------------------------------------
module ctc_bank #(
	parameter int CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  ctc_pkg::in_item_t  item,
	output ctc_pkg::out_item_t res,
	output logic               busy
);

	localparam int VW = (CHANNELS > ctc_pkg::IRQ_W) ? CHANNELS : ctc_pkg::IRQ_W;

	ctc_pkg::count_t            count_q  [CHANNELS];
	ctc_pkg::count_t            count_d  [CHANNELS];
	ctc_pkg::count_t            reload_q [CHANNELS];
	ctc_pkg::count_t            reload_d [CHANNELS];
	ctc_pkg::count_t            staged_q [CHANNELS];
	ctc_pkg::count_t            staged_d [CHANNELS];
	ctc_pkg::acc_t              acc_q    [CHANNELS];
	ctc_pkg::acc_t              acc_d    [CHANNELS];
	logic [1:0]                 sel_q    [CHANNELS];
	logic [1:0]                 sel_d    [CHANNELS];
	logic [CHANNELS-1:0]        en_q, en_d, cas_q, cas_d, irqen_q, irqen_d;
	logic [CHANNELS-1:0]        stflag_q, stflag_d;
	logic [CHANNELS-1:0]        cu_sel_q, cu_sel_d;
	logic [ctc_pkg::IRQ_W-1:0]  pend_irq_q, pend_irq_d;
	logic [ctc_pkg::FIFO_W-1:0] pend_fifo_q, pend_fifo_d;
	logic [VW-1:0]              ovf_v, irq_v;
	ctc_pkg::count_t            rd, cu_count, cu_reload;
	ctc_pkg::cu_ctl_t           cu_ctl;
	ctc_pkg::cu_stat_t          cu_stat;

	// counter and reload of the channel being caught up
	always_comb begin
		cu_count  = '0;
		cu_reload = '0;
		for (int n = 0; n < CHANNELS; n++) begin
			if (cu_sel_q[n]) begin
				cu_count  = cu_count | count_q[n];
				cu_reload = cu_reload | reload_q[n];
			end
		end
	end

	ctc_catchup u_catchup (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cu_ctl),
		.count  (cu_count),
		.reload (cu_reload),
		.stat   (cu_stat)
	);

	assign busy = cu_stat.busy;

	// per-channel update with overflow ripple from channel 0 upwards
	always_comb begin
		logic              carry, hit, runs, casc, step, inc, ovf, was_en, new_en;
		logic [3:0]        shift, shift_new;
		ctc_pkg::accx_t    acc1, dvs, dvs_new;
		ctc_pkg::count_t   cnt;

		count_d  = count_q;
		reload_d = reload_q;
		staged_d = staged_q;
		acc_d    = acc_q;
		sel_d    = sel_q;
		en_d     = en_q;
		cas_d    = cas_q;
		irqen_d  = irqen_q;
		stflag_d = stflag_q;
		cu_sel_d = cu_sel_q;
		cu_ctl   = '0;
		ovf_v    = '0;
		irq_v    = '0;
		rd       = '0;
		carry    = 1'b0;

		for (int n = 0; n < CHANNELS; n++) begin
			hit   = go && (int'(item.channel) == n);
			runs  = en_q[n] && !cas_q[n];
			casc  = en_q[n] && cas_q[n];
			shift = ctc_pkg::div_shift(sel_q[n]);
			dvs   = ctc_pkg::accx_t'(1) << shift;
			acc1  = ctc_pkg::accx_t'(acc_q[n]) + ctc_pkg::accx_t'(1);

			// one prescaled cycle: a tick, or the extra cycle on disable
			step = go && runs && ((item.kind == ctc_pkg::KIND_TICK)
				|| (hit && item.kind == ctc_pkg::KIND_CTRL
					&& !item.value[ctc_pkg::CTRL_EN_BIT]));
			inc = step && (acc1 >= dvs);
			if (step) begin
				acc_d[n] = ctc_pkg::acc_t'(inc ? acc1 - dvs : acc1);
			end

			// counter increment, wrap to reload, ripple into the cascade above
			ovf = 1'b0;
			cnt = count_q[n];
			if (cu_stat.busy && cu_sel_q[n]) begin
				ovf = cu_stat.ovf;
				cnt = cu_stat.count;
			end else if (inc || (casc && carry)) begin
				ovf = &count_q[n];
				cnt = ovf ? reload_q[n] : count_q[n] + ctc_pkg::count_t'(1);
			end
			carry      = ovf;
			count_d[n] = cnt;
			ovf_v[n]   = ovf;
			irq_v[n]   = ovf && irqen_q[n];

			// staged reload commits after the tick has been counted
			if (go && item.kind == ctc_pkg::KIND_TICK && runs && stflag_q[n]) begin
				reload_d[n] = staged_q[n];
				stflag_d[n] = 1'b0;
			end

			// addressed operation
			was_en    = en_q[n];
			new_en    = item.value[ctc_pkg::CTRL_EN_BIT];
			shift_new = ctc_pkg::div_shift(item.value[1:0]);
			dvs_new   = ctc_pkg::accx_t'(1) << shift_new;
			if (hit) begin
				case (item.kind)
					ctc_pkg::KIND_RELOAD: begin
						if (runs) begin
							staged_d[n] = item.value;
							stflag_d[n] = 1'b1;
						end else begin
							reload_d[n] = item.value;
							stflag_d[n] = 1'b0;
						end
					end
					ctc_pkg::KIND_CTRL: begin
						sel_d[n]   = item.value[1:0];
						en_d[n]    = new_en;
						cas_d[n]   = item.value[ctc_pkg::CTRL_CAS_BIT];
						irqen_d[n] = item.value[ctc_pkg::CTRL_IRQ_BIT];
						if (!was_en && new_en) begin
							// enable: take any staged value, load counter, restart prescaler
							if (stflag_q[n]) begin
								reload_d[n] = staged_q[n];
							end
							stflag_d[n] = 1'b0;
							count_d[n]  = stflag_q[n] ? staged_q[n] : reload_q[n];
							acc_d[n]    = ctc_pkg::ACC_START;
						end else if (was_en && new_en && !item.value[ctc_pkg::CTRL_CAS_BIT]
							&& (ctc_pkg::accx_t'(acc_q[n]) >= dvs_new)) begin
							// divisor dropped to or below the accumulator: owe increments
							cu_ctl.load  = 1'b1;
							cu_ctl.steps = ctc_pkg::steps_t'(
								acc_q[n][ctc_pkg::CU_W-1:0] >> shift_new);
							acc_d[n] = ctc_pkg::acc_t'({1'b0, acc_q[n][ctc_pkg::CU_W-1:0]
								& ctc_pkg::steps_t'(dvs_new - ctc_pkg::accx_t'(1))});
							cu_sel_d    = '0;
							cu_sel_d[n] = 1'b1;
						end
					end
					ctc_pkg::KIND_READ: begin
						rd = count_q[n];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// flags raised during catch-up go out with the next beat
	always_comb begin
		pend_irq_d  = pend_irq_q;
		pend_fifo_d = pend_fifo_q;
		if (cu_stat.busy) begin
			pend_irq_d  = pend_irq_q | irq_v[ctc_pkg::IRQ_W-1:0];
			pend_fifo_d = pend_fifo_q | ovf_v[ctc_pkg::FIFO_W-1:0];
		end else if (go) begin
			pend_irq_d  = '0;
			pend_fifo_d = '0;
		end
		res.read_data   = rd;
		res.irq_flags   = irq_v[ctc_pkg::IRQ_W-1:0] | pend_irq_q;
		res.fifo_notify = ovf_v[ctc_pkg::FIFO_W-1:0] | pend_fifo_q;
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < CHANNELS; n++) begin
				count_q[n]  <= '0;
				reload_q[n] <= '0;
				staged_q[n] <= '0;
				acc_q[n]    <= '0;
				sel_q[n]    <= ctc_pkg::PSC_DIV1;
			end
			en_q        <= '0;
			cas_q       <= '0;
			irqen_q     <= '0;
			stflag_q    <= '0;
			cu_sel_q    <= '0;
			pend_irq_q  <= '0;
			pend_fifo_q <= '0;
		end else begin
			count_q     <= count_d;
			reload_q    <= reload_d;
			staged_q    <= staged_d;
			acc_q       <= acc_d;
			sel_q       <= sel_d;
			en_q        <= en_d;
			cas_q       <= cas_d;
			irqen_q     <= irqen_d;
			stflag_q    <= stflag_d;
			cu_sel_q    <= cu_sel_d;
			pend_irq_q  <= pend_irq_d;
			pend_fifo_q <= pend_fifo_d;
		end
	end

endmodule

FILE: src/cascading_timer_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascading_timer_channels
// Bank of 16-bit reload timers with prescalers and overflow cascading.
// ----------------------------------------------------------------------------
// Usage:
//   item beats (item_valid / item_stall / item) carry one tick, reload write,
//   control write or counter read each; result beats (result_valid /
//   result_stall / result) return exactly one result per item, in order.
//   An accepted item waits in the input register and is processed in one
//   pass into the result register, which shows the result until taken.
//   Throughput is one item per cycle while result_stall is low and no
//   catch-up runs.
//   A control write that keeps a channel running non-cascaded with a new
//   divisor at or below its prescale accumulator leaves owed increments; the
//   catch-up sequencer works them off at one overflow of that channel per
//   cycle, holding the following item until it is done. Its flags are
//   reported with that following item.
//   Reset clears every channel: counters, reloads and modes to zero.
//   While result_stall is high the result holds; item_stall rises once the
//   input register is also full.
// ----------------------------------------------------------------------------
module cascading_timer_channels #(
	parameter int CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ctc_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output ctc_pkg::out_item_t result
);

	ctc_pkg::in_item_t  item_s1;
	logic               valid_s1;
	ctc_pkg::out_item_t res_d;
	ctc_pkg::out_item_t result_q;
	logic               result_valid_q;
	logic               out_free, go, busy;

	// process when the result register frees up and no catch-up runs
	assign out_free   = !result_valid_q || !result_stall;
	assign go         = valid_s1 && out_free && !busy;
	assign item_stall = valid_s1 && !go;

	ctc_bank #(
		.CHANNELS (CHANNELS)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.res    (res_d),
		.busy   (busy)
	);

	// input and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// beat payloads
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (go) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: src/ctc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_checker
// Port-level checks of the cascading timer channels: in-flight bound,
// result beats against accepted items, and flag consistency.
// ----------------------------------------------------------------------------
module ctc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input ctc_pkg::out_item_t result
);

	logic [1:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = item_valid && !item_stall;
	assign out_acc = result_valid && !result_stall;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// no result without an item behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != 2'd0)
		else $error("result beat without an accepted item");

	// at most the input and result registers hold items
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more items in flight than registers");

	// an empty block takes a beat at once
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'd0 |-> !item_stall)
		else $error("stall while empty");

	// irq on channel 0 or 1 implies its fifo notify
	a_irq_fifo: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.irq_flags[0] || result.fifo_notify[0])
			&& (!result.irq_flags[1] || result.fifo_notify[1]))
		else $error("irq flag without fifo notify");

endmodule

bind cascading_timer_channels ctc_checker u_ctc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
